/* hdl/sfl_pkg.sv */
// Shared types and constants for the serial firmware loader frame engine.
// No dependencies.
package sfl_pkg;
  localparam int unsigned PageBytes = 128;
  localparam int unsigned Words = (PageBytes + 3) / 4;
  localparam int unsigned PgIdxW = $clog2(PageBytes);
  localparam int unsigned WordIdxW = (Words > 1) ? $clog2(Words) : 1;

  localparam logic [7:0] ByteAck = 8'h79;
  localparam logic [7:0] ByteNak = 8'h1F;
  localparam logic [7:0] CmdWrite = 8'h11;
  localparam logic [7:0] CmdFinal = 8'h21;
  localparam logic [7:0] CmdWrite2 = 8'h31;

  typedef enum logic [1:0] {
    ActReply = 2'd0,
    ActBanner = 2'd1,
    ActErase = 2'd2,
    ActProgram = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CfgHeader = 1'b0,
    CfgFloor = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reply_byte;
    logic [31:0] flash_address;
    logic [31:0] program_word;
    logic busy_set;
    logic busy_clear_done;
    logic watchdog_kick;
    logic last;
  } result_t;

  // Controller to datapath: start a page program sweep.
  typedef struct packed {
    logic start;
    logic from_header;
    logic [31:0] base;
  } sweep_cmd_t;

  // Datapath to controller: sweep busy, word of the sweep ready, and final word flag.
  typedef struct packed {
    logic busy;
    logic word_valid;
    logic word_last;
  } sweep_sts_t;
endpackage

/* hdl/sfl_if.sv */
// Valid/ready channel interfaces for the loader.
// Depends on sfl_pkg.
interface sfl_byte_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  modport source(output valid, rx_byte, input ready);
  modport sink(input valid, rx_byte, output ready);
endinterface

interface sfl_result_if;
  logic valid;
  logic ready;
  sfl_pkg::result_t data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

interface sfl_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [31:0] wdata;
  modport source(output valid, index, wdata, input ready);
  modport sink(input valid, index, wdata, output ready);
endinterface

/* hdl/sfl_datapath.sv */
// Page stores and program-word sweep for the loader.
// Depends on sfl_pkg. Holds the two page memories with per-entry valid bits.
module sfl_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pb_we_i,
  input  logic [sfl_pkg::PgIdxW-1:0] pb_addr_i,
  input  logic [7:0] pb_wdata_i,
  input  logic copy_i,
  input  sfl_pkg::sweep_cmd_t cmd_i,
  input  logic advance_i,
  output sfl_pkg::sweep_sts_t sts_o,
  output logic [31:0] word_addr_o,
  output logic [31:0] word_o
);
  import sfl_pkg::*;

  logic [7:0] pb_mem [PageBytes];
  logic [7:0] hs_mem [PageBytes];
  logic [PageBytes-1:0] pb_vld_q, hs_vld_q;
  logic [7:0] pb_rd_q, hs_rd_q;
  logic [PgIdxW-1:0] rd_idx;

  // Sweep: one byte per cycle while no packed word waits for advance, copy (header stash) or pack words.
  logic running_q, copying_q, from_hdr_q, wvalid_q, wlast_q;
  logic [PgIdxW:0] cnt_q;
  logic rd_pend_q;
  logic [PgIdxW:0] rd_cnt_q;
  logic [31:0] base_q, word_q, word_addr_q;

  assign rd_idx = cnt_q[PgIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (pb_we_i) pb_mem[pb_addr_i] <= pb_wdata_i;
    pb_rd_q <= pb_mem[rd_idx];
    hs_rd_q <= hs_mem[rd_idx];
    if (copying_q && rd_pend_q) hs_mem[rd_cnt_q[PgIdxW-1:0]] <= pb_vld_q[rd_cnt_q[PgIdxW-1:0]]
                                                            ? pb_rd_q : 8'h00;
  end

  logic [7:0] rd_byte;
  assign rd_byte = from_hdr_q ? (hs_vld_q[rd_cnt_q[PgIdxW-1:0]] ? hs_rd_q : 8'h00)
                              : (pb_vld_q[rd_cnt_q[PgIdxW-1:0]] ? pb_rd_q : 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_vld_q <= '0;
      hs_vld_q <= '0;
      running_q <= 1'b0;
      copying_q <= 1'b0;
      from_hdr_q <= 1'b0;
      wvalid_q <= 1'b0;
      wlast_q <= 1'b0;
      rd_pend_q <= 1'b0;
      cnt_q <= '0;
      rd_cnt_q <= '0;
      base_q <= '0;
      word_q <= '0;
      word_addr_q <= '0;
    end else begin
      if (pb_we_i) pb_vld_q[pb_addr_i] <= 1'b1;
      if (copy_i) begin
        copying_q <= 1'b1;
        running_q <= 1'b1;
        from_hdr_q <= 1'b0;
        cnt_q <= '0;
        rd_pend_q <= 1'b0;
      end else if (cmd_i.start) begin
        copying_q <= 1'b0;
        running_q <= 1'b1;
        from_hdr_q <= cmd_i.from_header;
        base_q <= cmd_i.base;
        cnt_q <= '0;
        rd_pend_q <= 1'b0;
        word_q <= '0;
      end else if (running_q && !wvalid_q) begin
        rd_pend_q <= (cnt_q < (PgIdxW+1)'(PageBytes));
        rd_cnt_q <= cnt_q;
        if (cnt_q < (PgIdxW+1)'(PageBytes)) cnt_q <= cnt_q + 1'b1;
        if (copying_q) begin
          if (rd_pend_q) hs_vld_q[rd_cnt_q[PgIdxW-1:0]] <= 1'b1;
          if (rd_pend_q && rd_cnt_q == (PgIdxW+1)'(PageBytes - 1)) begin
            running_q <= 1'b0;
            copying_q <= 1'b0;
          end
        end else if (rd_pend_q || cnt_q == (PgIdxW+1)'(PageBytes)) begin
          // Pack byte into the word; emit on each fourth byte or at the end.
          if (rd_pend_q)
            word_q[8*rd_cnt_q[1:0] +: 8] <= rd_byte;
          if (rd_pend_q && (rd_cnt_q[1:0] == 2'd3 ||
              rd_cnt_q == (PgIdxW+1)'(PageBytes - 1))) begin
            wvalid_q <= 1'b1;
            wlast_q <= (rd_cnt_q == (PgIdxW+1)'(PageBytes - 1));
            word_addr_q <= base_q + 32'({rd_cnt_q[PgIdxW:2], 2'b00});
            rd_pend_q <= 1'b0;
            cnt_q <= cnt_q;
          end
        end
      end else if (wvalid_q && advance_i) begin
        wvalid_q <= 1'b0;
        word_q <= '0;
        if (wlast_q) running_q <= 1'b0;
      end
    end
  end

  assign sts_o.busy = running_q;
  assign sts_o.word_valid = wvalid_q;
  assign sts_o.word_last = wlast_q;
  assign word_addr_o = word_addr_q;
  assign word_o = word_q;
endmodule

/* hdl/sfl_ctrl.sv */
// Frame-parsing controller for the loader.
// Depends on sfl_pkg; drives sfl_datapath through command and status signals.
module sfl_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic [31:0] header_i,
  input  logic [31:0] floor_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output sfl_pkg::result_t out_o,
  output logic pb_we_o,
  output logic [sfl_pkg::PgIdxW-1:0] pb_addr_o,
  output logic [7:0] pb_wdata_o,
  output logic copy_o,
  output sfl_pkg::sweep_cmd_t cmd_o,
  output logic advance_o,
  input  sfl_pkg::sweep_sts_t sts_i,
  input  logic [31:0] word_addr_i,
  input  logic [31:0] word_i
);
  import sfl_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StOut, StCopy, StSweep, StAck
  } st_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0, PhArg = 2'd1, PhData = 2'd2, PhBad = 2'd3
  } ph_e;

  st_e st_q;
  ph_e phase_q;
  logic [7:0] cmd_q, xor_q;
  logic [8:0] idx_q, total_q;
  logic [31:0] waddr_q, argv_q;
  logic [7:0] ack_code_q;
  logic ack_bc_q, ack_wk_q;
  logic out_vld_q;
  result_t out_q;
  logic ob_free;

  assign ob_free = !out_vld_q || out_ready_i;
  assign in_ready_o = (st_q == StIdle) && ob_free;
  assign out_valid_o = out_vld_q;
  assign out_o = out_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // Page writes for argument and payload bytes.
  always_comb begin
    pb_we_o = 1'b0;
    pb_addr_o = idx_q[PgIdxW-1:0];
    pb_wdata_o = rx_byte_i;
    if (acc && phase_q == PhArg && idx_q < 9'(PageBytes)) pb_we_o = 1'b1;
    if (acc && phase_q == PhData && idx_q != 9'd0 && total_q >= idx_q &&
        (idx_q - 9'd1) < 9'(PageBytes)) begin
      pb_we_o = 1'b1;
      pb_addr_o = PgIdxW'(idx_q - 9'd1);
    end
  end

  function automatic result_t mk(input logic [1:0] a, input logic [7:0] r,
                                 input logic [31:0] ad, input logic [31:0] w,
                                 input logic bs, input logic bc, input logic wk,
                                 input logic l);
    result_t x;
    x.action = a; x.reply_byte = r; x.flash_address = ad; x.program_word = w;
    x.busy_set = bs; x.busy_clear_done = bc; x.watchdog_kick = wk; x.last = l;
    return x;
  endfunction

  logic [31:0] argval;
  logic [7:0] argx;
  assign argval = {argv_q[23:0], rx_byte_i};
  assign argx = argv_q[31:24] ^ argv_q[23:16] ^ argv_q[15:8] ^ argv_q[7:0];

  assign advance_o = (st_q == StSweep) && sts_i.word_valid && ob_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      phase_q <= PhIdle;
      cmd_q <= '0;
      xor_q <= '0;
      idx_q <= '0;
      total_q <= '0;
      waddr_q <= '0;
      argv_q <= '0;
      ack_code_q <= '0;
      ack_bc_q <= 1'b0;
      ack_wk_q <= 1'b0;
      out_vld_q <= 1'b0;
      out_q <= '0;
      copy_o <= 1'b0;
      cmd_o <= '0;
    end else begin
      copy_o <= 1'b0;
      cmd_o.start <= 1'b0;
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (acc) begin
            unique case (phase_q)
              PhIdle: begin
                priority case (idx_q)
                  9'd0: begin
                    if (rx_byte_i == 8'h0A) begin
                      cmd_q <= '0;
                    end else if (rx_byte_i == 8'h57 || rx_byte_i == 8'h77) begin
                      idx_q <= 9'd1;
                    end else if (rx_byte_i == CmdWrite || rx_byte_i == CmdFinal ||
                                 rx_byte_i == CmdWrite2) begin
                      cmd_q <= rx_byte_i;
                      idx_q <= 9'd1;
                    end else cmd_q <= '0;
                  end
                  9'd1: begin
                    idx_q <= '0;
                    if (rx_byte_i == 8'h48 || rx_byte_i == 8'h68) idx_q <= 9'd2;
                    else begin
                      xor_q <= '0; waddr_q <= '0; cmd_q <= '0; phase_q <= PhIdle;
                      out_vld_q <= 1'b1;
                      if ((rx_byte_i == 8'hEE && cmd_q == CmdWrite) ||
                          (rx_byte_i == 8'hDE && cmd_q == CmdFinal) ||
                          (rx_byte_i == 8'hCE && cmd_q == CmdWrite2)) begin
                        out_q <= mk(ActReply, ByteAck, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                        cmd_q <= ~rx_byte_i;
                        phase_q <= PhArg;
                      end else
                        out_q <= mk(ActReply, ByteNak, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    end
                  end
                  9'd2: idx_q <= (rx_byte_i == 8'h4F || rx_byte_i == 8'h6F) ? 9'd3 : 9'd0;
                  9'd3: idx_q <= (rx_byte_i == 8'h3F) ? 9'd4 : 9'd0;
                  9'd4: begin
                    idx_q <= '0;
                    if (rx_byte_i == 8'h0D) begin
                      out_vld_q <= 1'b1;
                      out_q <= mk(ActBanner, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                      xor_q <= '0; waddr_q <= '0; cmd_q <= '0;
                    end
                  end
                  default: idx_q <= '0;
                endcase
              end
              PhArg: begin
                if (idx_q < 9'd4) begin
                  argv_q <= argval;
                  idx_q <= idx_q + 9'd1;
                end else begin
                  idx_q <= '0;
                  xor_q <= argx;
                  if (rx_byte_i != argx || argv_q <= floor_i) begin
                    out_vld_q <= 1'b1;
                    out_q <= mk(ActReply, ByteNak, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    xor_q <= '0; waddr_q <= '0; cmd_q <= '0; phase_q <= PhIdle;
                  end else if (cmd_q == CmdWrite || cmd_q == CmdWrite2) begin
                    out_vld_q <= 1'b1;
                    out_q <= mk(ActReply, ByteAck, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1);
                    xor_q <= '0; cmd_q <= '0;
                    waddr_q <= argv_q;
                    phase_q <= PhData;
                  end else if (cmd_q == CmdFinal) begin
                    xor_q <= '0; waddr_q <= '0; cmd_q <= '0; phase_q <= PhIdle;
                    if (argv_q == header_i) begin
                      cmd_o.start <= 1'b1;
                      cmd_o.from_header <= 1'b1;
                      cmd_o.base <= argv_q;
                      ack_code_q <= ByteAck; ack_bc_q <= 1'b1; ack_wk_q <= 1'b0;
                      st_q <= StSweep;
                    end else begin
                      out_vld_q <= 1'b1;
                      out_q <= mk(ActReply, ByteNak, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    end
                  end
                end
              end
              PhData: begin
                if (idx_q == 9'd0) begin
                  xor_q <= rx_byte_i;
                  total_q <= {1'b0, rx_byte_i} + 9'd1;
                  idx_q <= 9'd1;
                end else if (total_q >= idx_q) begin
                  xor_q <= xor_q ^ rx_byte_i;
                  idx_q <= idx_q + 9'd1;
                end else if (rx_byte_i != xor_q) begin
                  out_vld_q <= 1'b1;
                  out_q <= mk(ActReply, ByteNak, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                  xor_q <= '0; waddr_q <= '0; cmd_q <= '0; phase_q <= PhIdle;
                  idx_q <= '0;
                end else begin
                  out_vld_q <= 1'b1;
                  out_q <= mk(ActErase, '0, waddr_q, '0, 1'b0, 1'b0, 1'b0, 1'b0);
                  ack_code_q <= ByteAck; ack_bc_q <= 1'b0; ack_wk_q <= 1'b1;
                  if (waddr_q == header_i) begin
                    copy_o <= 1'b1;
                    st_q <= StCopy;
                  end else begin
                    cmd_o.start <= 1'b1;
                    cmd_o.from_header <= 1'b0;
                    cmd_o.base <= waddr_q;
                    st_q <= StSweep;
                  end
                  xor_q <= '0; waddr_q <= '0; cmd_q <= '0; phase_q <= PhIdle;
                  idx_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        StCopy: begin
          // Wait for the stash copy to start and finish.
          if (!copy_o && !sts_i.busy) st_q <= StAck;
        end
        StSweep: begin
          if (advance_o) begin
            out_vld_q <= 1'b1;
            out_q <= mk(ActProgram, '0, word_addr_i, word_i, 1'b0, 1'b0, 1'b0, 1'b0);
            if (sts_i.word_last) st_q <= StAck;
          end
        end
        StAck: begin
          if (ob_free) begin
            out_vld_q <= 1'b1;
            out_q <= mk(ActReply, ack_code_q, '0, '0, 1'b0, ack_bc_q, ack_wk_q, 1'b1);
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

/* hdl/serial_firmware_loader_frame_engine.sv */
// Top level of the serial firmware loader frame engine.
// Depends on sfl_pkg, sfl_if, sfl_ctrl and sfl_datapath.
//
// Usage: host bytes enter on the in_if channel one byte at a time; results
// leave on out_if, the last one of each byte flagged by last. The cfg_if
// channel writes the header page address (index 0) and the address floor
// (index 1); the user must write them only while the engine is idle, which
// the block does not enforce. A byte that produces a single reply shows it in
// the cycle after acceptance. A committed block gives an erase, PAGE_BYTES/4
// program words and an ACK, or for the header page an erase, a stash copy and
// an ACK; a finalise gives the stash's program words and an ACK. The word sweep
// reads one page byte per cycle while no packed word waits to be taken. A
// header stash copies one byte per cycle.
// One byte is processed at a time; the next byte is accepted once the
// previous one's results are all issued and the output register is free or being taken.
// Reset clears the parser state and marks both page stores as all zeros
// through per-byte valid bits; no clearing pass is needed.
// A stalled receiver holds the output register and pauses the sweep.
module serial_firmware_loader_frame_engine (
  input  logic clk_i,
  input  logic rst_ni,
  sfl_byte_if.sink in_if,
  sfl_result_if.source out_if,
  sfl_cfg_if.sink cfg_if
);
  import sfl_pkg::*;

  logic [31:0] header_q, floor_q;
  logic pb_we, copy, advance;
  logic [PgIdxW-1:0] pb_addr;
  logic [7:0] pb_wdata;
  sweep_cmd_t cmd;
  sweep_sts_t sts;
  logic [31:0] word_addr, word;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
      floor_q <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_e'(cfg_if.index))
        CfgHeader: header_q <= cfg_if.wdata;
        CfgFloor: floor_q <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  sfl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .rx_byte_i(in_if.rx_byte),
    .header_i(header_q), .floor_i(floor_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_o(out_if.data),
    .pb_we_o(pb_we), .pb_addr_o(pb_addr), .pb_wdata_o(pb_wdata),
    .copy_o(copy), .cmd_o(cmd), .advance_o(advance), .sts_i(sts),
    .word_addr_i(word_addr), .word_i(word)
  );

  sfl_datapath u_dp (
    .clk_i, .rst_ni,
    .pb_we_i(pb_we), .pb_addr_i(pb_addr), .pb_wdata_i(pb_wdata),
    .copy_i(copy), .cmd_i(cmd), .advance_i(advance), .sts_o(sts),
    .word_addr_o(word_addr), .word_o(word)
  );
endmodule

/* dv/sfl_tb_if.sv */
`timescale 1ns / 1ps
// Testbench view of the loader channels: nothing extra, the interfaces come
// from the RTL file sfl_if.sv. This file only holds shared testbench types.
// Depends on sfl_pkg.
package sfl_tb_pkg;
  import sfl_pkg::*;
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhArg  = 2'd1,
    PhData = 2'd2
  } parse_phase_e;
endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for serial_firmware_loader_frame_engine: byte frames
// (keepalive, command pairs, address arguments, data blocks) are driven,
// and every result is checked against an in-bench protocol predictor.
// Depends on sfl_pkg, sfl_if, sfl_tb_pkg and the RTL.
module testbench;
  import sfl_pkg::*;
  import sfl_tb_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i;
  logic rst_ni;

  sfl_byte_if   in_if ();
  sfl_result_if out_if ();
  sfl_cfg_if    cfg_if ();

  serial_firmware_loader_frame_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Predictor state.
  parse_phase_e phase_q;
  logic [7:0]   cmd_q;
  logic [8:0]   idx_q;
  logic [7:0]   xor_q;
  logic [8:0]   total_q;
  logic [31:0]  waddr_q;
  logic [7:0]   page_mem [PageBytes];
  logic [7:0]   hdr_mem [PageBytes];
  logic [31:0]  hdr_page_cfg;
  logic [31:0]  floor_cfg;

  result_t      expected_q[$];
  logic [7:0]   pending_bytes[$];
  int           errors;
  int           stall_pct;
  int           gap_pct;
  bit           hold_off;
  int           idle_cycles;
  bit           accepted_in;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what, input result_t got, input result_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic result_t mk_res(input action_e act, input logic [7:0] rep,
                                     input logic [31:0] addr, input logic [31:0] word);
    result_t r;
    r = '0;
    r.action = act;
    r.reply_byte = rep;
    r.flash_address = addr;
    r.program_word = word;
    return r;
  endfunction

  task automatic push_reply(input logic [7:0] code, input bit bs, input bit bc,
                            input bit wk);
    result_t r;
    r = mk_res(ActReply, code, '0, '0);
    r.busy_set = bs;
    r.busy_clear_done = bc;
    r.watchdog_kick = wk;
    expected_q.push_back(r);
    xor_q = '0;
    waddr_q = '0;
    cmd_q = '0;
    phase_q = PhIdle;
    idx_q = '0;
  endtask

  task automatic push_page_words(input bit from_hdr, input logic [31:0] base);
    logic [31:0] w;
    for (int i = 0; i < Words; i++) begin
      w = '0;
      for (int j = 0; j < 4; j++) begin
        if (i * 4 + j < PageBytes)
          w[8*j +: 8] = from_hdr ? hdr_mem[i*4+j] : page_mem[i*4+j];
      end
      expected_q.push_back(mk_res(ActProgram, '0, base + 32'(i * 4), w));
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    int n0;
    logic [31:0] val;
    n0 = expected_q.size();
    case (phase_q)
      PhIdle: begin
        case (idx_q)
          9'd0: begin
            if (b == 8'h0A) begin
              cmd_q = '0;
            end else if (b == 8'h57 || b == 8'h77) begin
              idx_q = 9'd1;
            end else if (b == CmdWrite || b == CmdFinal || b == CmdWrite2) begin
              cmd_q = b;
              idx_q = 9'd1;
            end else begin
              cmd_q = '0;
            end
          end
          9'd1: begin
            if (b == 8'h48 || b == 8'h68) begin
              idx_q = 9'd2;
            end else if ((b == 8'hEE && cmd_q == CmdWrite) ||
                         (b == 8'hDE && cmd_q == CmdFinal) ||
                         (b == 8'hCE && cmd_q == CmdWrite2)) begin
              push_reply(ByteAck, 0, 0, 0);
              cmd_q = ~b;
              phase_q = PhArg;
            end else begin
              push_reply(ByteNak, 0, 0, 0);
            end
          end
          9'd2: idx_q = (b == 8'h4F || b == 8'h6F) ? 9'd3 : 9'd0;
          9'd3: idx_q = (b == 8'h3F) ? 9'd4 : 9'd0;
          9'd4: begin
            if (b == 8'h0D) begin
              expected_q.push_back(mk_res(ActBanner, '0, '0, '0));
              xor_q = '0;
              waddr_q = '0;
              cmd_q = '0;
            end
            idx_q = '0;
          end
          default: idx_q = '0;
        endcase
      end
      PhArg: begin
        if (idx_q < PageBytes) page_mem[PgIdxW'(idx_q)] = b;
        idx_q++;
        if (idx_q > 4) begin
          idx_q = '0;
          xor_q = page_mem[0] ^ page_mem[1] ^ page_mem[2] ^ page_mem[3];
          val = {page_mem[0], page_mem[1], page_mem[2], page_mem[3]};
          if (page_mem[4] != xor_q || val <= floor_cfg) begin
            push_reply(ByteNak, 0, 0, 0);
          end else if (cmd_q == CmdWrite || cmd_q == CmdWrite2) begin
            push_reply(ByteAck, 1, 0, 0);
            waddr_q = val;
            phase_q = PhData;
          end else if (cmd_q == CmdFinal) begin
            if (val == hdr_page_cfg) begin
              push_page_words(1'b1, val);
              push_reply(ByteAck, 0, 1, 0);
            end else begin
              push_reply(ByteNak, 0, 0, 0);
            end
          end
        end
      end
      PhData: begin
        if (idx_q == 0) begin
          xor_q = b;
          total_q = 9'(b) + 9'd1;
          idx_q = 9'd1;
        end else if (total_q >= idx_q) begin
          if (idx_q - 1 < PageBytes) page_mem[PgIdxW'(idx_q - 9'd1)] = b;
          xor_q ^= b;
          idx_q = idx_q + 9'd1;
        end else if (b != xor_q) begin
          push_reply(ByteNak, 0, 0, 0);
        end else begin
          expected_q.push_back(mk_res(ActErase, '0, waddr_q, '0));
          if (waddr_q == hdr_page_cfg) begin
            for (int k = 0; k < PageBytes; k++) hdr_mem[k] = page_mem[k];
          end else begin
            push_page_words(1'b0, waddr_q);
          end
          push_reply(ByteAck, 0, 0, 1);
        end
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endtask

  // Stimulus builders.
  task automatic q_cmd(input logic [7:0] c);
    pending_bytes.push_back(c);
    pending_bytes.push_back(~c);
  endtask

  task automatic q_arg(input logic [31:0] a, input bit bad);
    logic [7:0] x;
    x = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
    pending_bytes.push_back(a[31:24]);
    pending_bytes.push_back(a[23:16]);
    pending_bytes.push_back(a[15:8]);
    pending_bytes.push_back(a[7:0]);
    pending_bytes.push_back(bad ? ~x : x);
  endtask

  task automatic q_block(input int len, input bit bad);
    logic [7:0] x;
    logic [7:0] d;
    x = 8'(len);
    pending_bytes.push_back(8'(len));
    for (int i = 0; i <= len; i++) begin
      d = 8'($urandom);
      x ^= d;
      pending_bytes.push_back(d);
    end
    pending_bytes.push_back(bad ? ~x : x);
  endtask

  task automatic q_write(input logic [7:0] c, input logic [31:0] a, input int len);
    q_cmd(c);
    q_arg(a, 1'b0);
    q_block(len, $urandom_range(0, 9) == 0);
  endtask

  task automatic q_keepalive(input bit lower);
    pending_bytes.push_back(lower ? 8'h77 : 8'h57);
    pending_bytes.push_back(lower ? 8'h68 : 8'h48);
    pending_bytes.push_back(lower ? 8'h6F : 8'h4F);
    pending_bytes.push_back(8'h3F);
    pending_bytes.push_back(8'h0D);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [31:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgHeader) hdr_page_cfg = v;
    else floor_cfg = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Driver: offer the next queued byte at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.rx_byte <= '0;
      out_if.ready <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) ; // handled at the rising edge
      if (!in_if.valid || accepted_in) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          in_if.valid <= 1'b1;
          in_if.rx_byte <= pending_bytes[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Acceptance is recorded at the rising edge; the driver reads it at the
  // next falling edge.
  always @(posedge clk_i) begin
    accepted_in <= 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      accepted_in <= 1'b1;
      predict_byte(pending_bytes.pop_front());
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_if.data, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_if.data.action != want.action) report("action", out_if.data, want);
        else if (out_if.data.reply_byte != want.reply_byte)
          report("reply_byte", out_if.data, want);
        else if (out_if.data.flash_address != want.flash_address)
          report("flash_address", out_if.data, want);
        else if (out_if.data.program_word != want.program_word)
          report("program_word", out_if.data, want);
        else if (out_if.data.busy_set != want.busy_set)
          report("busy_set", out_if.data, want);
        else if (out_if.data.busy_clear_done != want.busy_clear_done)
          report("busy_clear_done", out_if.data, want);
        else if (out_if.data.watchdog_kick != want.watchdog_kick)
          report("watchdog_kick", out_if.data, want);
        else if (out_if.data.last != want.last)
          report("last", out_if.data, want);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    logic [31:0] a;
    errors = 0;
    stall_pct = 0;
    gap_pct = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgHeader;
    cfg_if.wdata = '0;
    phase_q = PhIdle;
    cmd_q = '0;
    idx_q = '0;
    xor_q = '0;
    total_q = '0;
    waddr_q = '0;
    hdr_page_cfg = '0;
    floor_cfg = '0;
    for (int k = 0; k < PageBytes; k++) begin
      page_mem[k] = '0;
      hdr_mem[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    write_cfg(CfgHeader, 32'h0800_4000);
    write_cfg(CfgFloor, 32'h0800_0000);
    q_keepalive(1'b0);
    q_keepalive(1'b1);
    pending_bytes.push_back(8'h57);      // keepalive broken early
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h0A);
    q_cmd(CmdFinal);                      // finalise of the still-clear stash
    q_arg(32'h0800_4000, 1'b0);
    q_cmd(CmdWrite);
    q_arg(32'h0800_0000, 1'b0);          // at the floor: refused
    q_cmd(CmdWrite2);
    q_arg(32'hFFFF_FFFC, 1'b1);          // bad check
    pending_bytes.push_back(CmdWrite);   // wrong complement
    pending_bytes.push_back(8'h00);
    wait_drained();

    hold_off = 1'b1;
    q_write(CmdWrite, 32'hFFFF_FFF0, 129);  // oversized, address wraps
    q_write(CmdWrite2, 32'h0800_4000, 0);   // stashed header
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    q_cmd(CmdFinal);
    q_arg(32'h0800_4000, 1'b0);
    wait_drained();

    // Random part across idling phases and register settings.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 45; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 45; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      write_cfg(CfgFloor, (p == 3) ? 32'hFFFF_FFFF : ((p == 2) ? 32'h0 : 32'h0000_1000));
      write_cfg(CfgHeader, (p == 1) ? 32'hFFFF_FFFF : 32'h0000_2000);
      for (int t = 0; t < 2; t++) begin
        kind = $urandom_range(0, 9);
        a = ($urandom_range(0, 3) == 0) ? hdr_page_cfg : $urandom;
        if (kind < 5) begin
          q_write($urandom_range(0, 1) ? CmdWrite : CmdWrite2, a, $urandom_range(0, 7));
        end else if (kind < 7) begin
          q_cmd(CmdFinal);
          q_arg(a, $urandom_range(0, 7) == 0);
        end else if (kind == 7) begin
          q_keepalive($urandom_range(0, 1));
        end else begin
          repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom));
          pending_bytes.push_back(8'h0A);
        end
      end
      wait_drained();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* serial_firmware_loader_frame_engine.f */
hdl/sfl_pkg.sv
hdl/sfl_if.sv
hdl/sfl_datapath.sv
hdl/sfl_ctrl.sv
hdl/serial_firmware_loader_frame_engine.sv
dv/sfl_tb_if.sv
dv/testbench.sv
